// ===== sv/pcat_pkg.sv =====
// ----------------------------------------------------------------------------
// pcat_pkg
// shared constants, codes and table selects for the pseudocost average table
// ----------------------------------------------------------------------------
package pcat_pkg;

  localparam int DEF_MAX_POINTS  = 1024;
  localparam int DEF_MAX_CLASSES = 64;
  localparam int DEF_FRAC_BITS   = 16;

  // configuration register indexes
  localparam logic [0:0] REG_POINTS_IN_USE  = 1'b0;
  localparam logic [0:0] REG_CLASSES_IN_USE = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_INDEX  = 2'd1;
  localparam logic [1:0] ERR_ZERO_SCALE = 2'd2;

  // table numbers
  localparam logic [1:0] TBL_POINT_UP   = 2'd0;
  localparam logic [1:0] TBL_POINT_DOWN = 2'd1;
  localparam logic [1:0] TBL_CLASS_UP   = 2'd2;
  localparam logic [1:0] TBL_CLASS_DOWN = 2'd3;

  localparam int SUM_W  = 48;
  localparam int CNT_W  = 16;
  localparam int COST_W = 32;

endpackage

// ===== sv/pcat_ram.sv =====
// ----------------------------------------------------------------------------
// pcat_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pcat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/pcat_divider.sv =====
// ----------------------------------------------------------------------------
// pcat_divider
// bit serial signed divider, one quotient bit per cycle, truncates to zero
// ----------------------------------------------------------------------------
module pcat_divider #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] qreg;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem[DW-1:0], qreg[NW-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        neg  <= num[NW-1];
        qreg <= num[NW-1] ? NW'(-num) : NW'(num);
        rem  <= '0;
      end else if (busy) begin
        if (trial[DW]) begin
          rem  <= shifted;
          qreg <= {qreg[NW-2:0], 1'b0};
        end else begin
          rem  <= trial;
          qreg <= {qreg[NW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(qreg) : $signed(qreg);
endmodule

// ===== sv/pseudocost_average_table.sv =====
// ----------------------------------------------------------------------------
// pseudocost_average_table
// four pseudocost tables with per entry average cost and table averages
// ----------------------------------------------------------------------------
// divisions: a result takes three serial divisions of 81 bits through one
//   shared bit serial divider, plus sequencing; error results skip them.
// requests: one at a time; a new one is accepted once the last result is taken.
// reset: synchronous, clears control state and totals, then a clearing pass
//   zeroes counts and sums and sets costs to 1.0 before ready
module pseudocost_average_table #(
  parameter int MAX_POINTS  = pcat_pkg::DEF_MAX_POINTS,
  parameter int MAX_CLASSES = pcat_pkg::DEF_MAX_CLASSES,
  parameter int FRAC_BITS   = pcat_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // request: tdata = entry_index[9:0], gain[41:10], scale[72:42], pad to 80
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,
  // tuser = is_point_table[0], is_up_direction[1]
  input  logic [1:0]  s_tuser,
  // result: tdata = entry_cost[31:0], table_average[63:32],
  //   entry_updates[79:64], update_error[81:80], pad to 88
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata
);
  import pcat_pkg::*;

  localparam int PAW = (MAX_POINTS  > 1) ? $clog2(MAX_POINTS)  : 1;
  localparam int CAW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int EAW = (PAW > CAW) ? PAW : CAW;
  localparam int MAXD = (MAX_POINTS > MAX_CLASSES) ? MAX_POINTS : MAX_CLASSES;
  localparam int DNW = 32 + FRAC_BITS + 1 > SUM_W ? 32 + FRAC_BITS + 1 : SUM_W;
  localparam int ACW = $clog2(MAX_POINTS + 1) + 1;
  localparam int EW  = 48;   // totals width

  // states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_QDIV  = 4'd2;
  localparam logic [3:0] ST_QWAIT = 4'd3;
  localparam logic [3:0] ST_CDIV  = 4'd4;
  localparam logic [3:0] ST_CWAIT = 4'd5;
  localparam logic [3:0] ST_ADIV  = 4'd6;
  localparam logic [3:0] ST_AWAIT = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;
  localparam logic [3:0] ST_SUMQ  = 4'd9;
  localparam logic [3:0] ST_CLEAR = 4'd10;

  logic [3:0]  state;
  logic [10:0] points_in_use;
  logic [6:0]  classes_in_use;

  // captured request
  logic [9:0]        idx;
  logic signed [31:0] gain;
  logic [30:0]       scale;
  logic [1:0]        tsel;

  // per table totals
  logic signed [EW-1:0] totals  [4];
  logic [ACW-1:0]       actives [4];

  // result registers
  logic signed [31:0] r_cost;
  logic signed [31:0] r_avg;
  logic [15:0]        r_cnt;
  logic [1:0]         r_err;

  // working registers
  logic signed [SUM_W-1:0] sum;
  logic [15:0]             old_cnt;
  logic signed [31:0]      old_cost;
  logic signed [31:0]      q;

  assign cfg_ready = (state == ST_IDLE) && !m_tvalid;
  assign s_tready  = (state == ST_IDLE) && !m_tvalid;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use  <= 11'd1024;
      classes_in_use <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINTS_IN_USE:  points_in_use  <= cfg_data;
        REG_CLASSES_IN_USE: classes_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // memories: sums, counts and costs, cleared by a pass after reset
  logic [EAW-1:0]        ram_addr;
  logic [EAW-1:0]        clr_addr;
  logic                  clearing;
  logic                  we;
  logic [SUM_W-1:0]      sum_rd [4];
  logic [CNT_W-1:0]      cnt_rd [4];
  logic [COST_W-1:0]     cost_rd [4];
  logic [SUM_W-1:0]      sum_wr;
  logic [CNT_W-1:0]      cnt_wr;
  logic [COST_W-1:0]     cost_wr;

  assign clearing = (state == ST_CLEAR);

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_tbl
      localparam int D  = (g < 2) ? MAX_POINTS : MAX_CLASSES;
      localparam int AW = (g < 2) ? PAW : CAW;
      logic wsel;
      assign wsel = clearing || (we && (tsel == 2'(g)));
      pcat_ram #(.WIDTH(SUM_W), .DEPTH(D)) u_sum (
        .clk(clk), .we(wsel), .addr(ram_addr[AW-1:0]), .wdata(sum_wr),
        .rdata(sum_rd[g]));
      pcat_ram #(.WIDTH(CNT_W), .DEPTH(D)) u_cnt (
        .clk(clk), .we(wsel), .addr(ram_addr[AW-1:0]), .wdata(cnt_wr),
        .rdata(cnt_rd[g]));
      pcat_ram #(.WIDTH(COST_W), .DEPTH(D)) u_cost (
        .clk(clk), .we(wsel), .addr(ram_addr[AW-1:0]), .wdata(cost_wr),
        .rdata(cost_rd[g]));
    end
  endgenerate

  assign ram_addr = clearing ? clr_addr : idx[EAW-1:0];

  // shared divider
  logic                  dstart;
  logic signed [DNW+31:0] dnum;
  logic [31:0]           dden;
  logic                  ddone;
  logic signed [DNW+31:0] dquo;

  pcat_divider #(.NW(DNW + 32), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo));

  // saturation helpers on the divider result and the running sum
  logic signed [31:0]      quo_sat32;
  logic signed [SUM_W:0]   sum_add;
  logic signed [SUM_W-1:0] sum_sat;
  always_comb begin
    if (dquo > $signed((DNW+32)'(32'sh7fffffff)))
      quo_sat32 = 32'sh7fffffff;
    else if (dquo < -$signed((DNW+32)'(64'sh80000000)))
      quo_sat32 = 32'sh80000000;
    else
      quo_sat32 = dquo[31:0];
    sum_add = (old_cnt == 16'd0 ? (SUM_W+1)'(0) : (SUM_W+1)'(sum)) + (SUM_W+1)'(q);
    if (sum_add[SUM_W] != sum_add[SUM_W-1])
      sum_sat = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_sat = sum_add[SUM_W-1:0];
  end

  logic [10:0] limit;
  always_comb begin
    if (s_tuser[0])
      limit = (points_in_use > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : points_in_use;
    else
      limit = ({4'd0, classes_in_use} > 11'(MAX_CLASSES)) ? 11'(MAX_CLASSES)
              : {4'd0, classes_in_use};
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      dstart   <= 1'b0;
      we       <= 1'b0;
      sum_wr   <= '0;
      cnt_wr   <= '0;
      cost_wr  <= COST_W'(1 << FRAC_BITS);
      for (int i = 0; i < 4; i++) begin
        totals[i]  <= '0;
        actives[i] <= '0;
      end
    end else begin
      dstart <= 1'b0;
      we     <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == EAW'(MAXD - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            idx      <= s_tdata[9:0];
            gain     <= s_tdata[41:10];
            scale    <= s_tdata[72:42];
            tsel     <= s_tuser[0] ? (s_tuser[1] ? TBL_POINT_UP : TBL_POINT_DOWN)
                                   : (s_tuser[1] ? TBL_CLASS_UP : TBL_CLASS_DOWN);
            r_cost <= '0; r_avg <= '0; r_cnt <= '0;
            if ({1'b0, s_tdata[9:0]} >= limit) begin
              r_err <= ERR_BAD_INDEX;
              state <= ST_OUT;
            end else if (s_tdata[72:42] == 31'd0) begin
              r_err <= ERR_ZERO_SCALE;
              state <= ST_OUT;
            end else begin
              r_err <= ERR_NONE;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // ram read data is ready next cycle; start quotient now
          dnum   <= (DNW+32)'(gain) <<< FRAC_BITS;
          dden   <= {1'b0, scale};
          dstart <= 1'b1;
          state  <= ST_QDIV;
        end
        ST_QDIV: begin
          sum      <= $signed(sum_rd[tsel]);
          old_cnt  <= cnt_rd[tsel];
          old_cost <= $signed(cost_rd[tsel]);
          state    <= ST_QWAIT;
        end
        ST_QWAIT: begin
          if (ddone) begin
            q     <= quo_sat32;
            state <= ST_SUMQ;
          end
        end
        ST_SUMQ: begin
          sum     <= sum_sat;
          r_cnt   <= (old_cnt == 16'hffff) ? old_cnt : old_cnt + 16'd1;
          dnum    <= (DNW+32)'(sum_sat);
          dden    <= {16'd0, (old_cnt == 16'hffff) ? old_cnt : old_cnt + 16'd1};
          dstart  <= 1'b1;
          state   <= ST_CDIV;
        end
        ST_CDIV: state <= ST_CWAIT;
        ST_CWAIT: begin
          if (ddone) begin
            r_cost  <= quo_sat32;
            sum_wr  <= sum;
            cnt_wr  <= r_cnt;
            cost_wr <= quo_sat32;
            we      <= 1'b1;
            if (old_cnt == 16'd0) begin
              actives[tsel] <= actives[tsel] + 1'b1;
              totals[tsel]  <= totals[tsel] + EW'(quo_sat32);
              dnum <= (DNW+32)'(totals[tsel] + EW'(quo_sat32));
              dden <= 32'(actives[tsel] + 1'b1);
            end else begin
              totals[tsel] <= totals[tsel] + EW'(quo_sat32) - EW'(old_cost);
              dnum <= (DNW+32)'(totals[tsel] + EW'(quo_sat32) - EW'(old_cost));
              dden <= 32'(actives[tsel]);
            end
            dstart <= 1'b1;
            state  <= ST_ADIV;
          end
        end
        ST_ADIV: state <= ST_AWAIT;
        ST_AWAIT: begin
          if (ddone) begin
            r_avg <= quo_sat32;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          m_tvalid <= 1'b1;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'd0, r_err, r_cnt, r_avg, r_cost};
endmodule
